// File: src/sstg_pkg.sv
// ----------------------------------------------------------------------------
// sstg_pkg
// Shared types, codes and lookup functions for the seven-segment
// triangle generator.
// ----------------------------------------------------------------------------
package sstg_pkg;

  // request commands
  localparam logic CMD_DIGIT = 1'b0;
  localparam logic CMD_SHAPE = 1'b1;

  // shape codes
  localparam logic [3:0] SH_A       = 4'd0;
  localparam logic [3:0] SH_B       = 4'd1;
  localparam logic [3:0] SH_C       = 4'd2;
  localparam logic [3:0] SH_D       = 4'd3;
  localparam logic [3:0] SH_E       = 4'd4;
  localparam logic [3:0] SH_F       = 4'd5;
  localparam logic [3:0] SH_G       = 4'd6;
  localparam logic [3:0] SH_DOT     = 4'd7;
  localparam logic [3:0] SH_COL_TOP = 4'd8;
  localparam logic [3:0] SH_COL_BOT = 4'd9;
  localparam logic [3:0] SH_SLASH   = 4'd10;

  localparam int MAX_SHAPES = 7;

  // list of shapes one request draws, codes[0] first
  typedef struct packed {
    logic [2:0]                       cnt;
    logic [MAX_SHAPES-1:0][3:0]       codes;
  } plan_t;

  // corner of a shape in units of scale
  typedef struct packed {
    logic       known;
    logic [2:0] x;
    logic [3:0] y;
  } corner_t;

  function automatic plan_t digit_plan(logic [3:0] digit);
    plan_t p;
    p.cnt   = 3'd0;
    p.codes = '0;
    unique case (digit)
      4'd0: begin
        p.cnt = 3'd6; p.codes = {SH_A, SH_F, SH_E, SH_D, SH_C, SH_B, SH_A};
      end
      4'd1: begin
        p.cnt = 3'd2; p.codes = {SH_A, SH_A, SH_A, SH_A, SH_A, SH_C, SH_B};
      end
      4'd2: begin
        p.cnt = 3'd5; p.codes = {SH_A, SH_A, SH_D, SH_E, SH_G, SH_B, SH_A};
      end
      4'd3: begin
        p.cnt = 3'd5; p.codes = {SH_A, SH_A, SH_D, SH_C, SH_G, SH_B, SH_A};
      end
      4'd4: begin
        p.cnt = 3'd4; p.codes = {SH_A, SH_A, SH_A, SH_F, SH_G, SH_C, SH_B};
      end
      4'd5: begin
        p.cnt = 3'd5; p.codes = {SH_A, SH_A, SH_D, SH_C, SH_G, SH_F, SH_A};
      end
      4'd6: begin
        p.cnt = 3'd6; p.codes = {SH_A, SH_E, SH_D, SH_C, SH_G, SH_F, SH_A};
      end
      4'd7: begin
        p.cnt = 3'd3; p.codes = {SH_A, SH_A, SH_A, SH_A, SH_C, SH_B, SH_A};
      end
      4'd8: begin
        p.cnt = 3'd7; p.codes = {SH_G, SH_F, SH_E, SH_D, SH_C, SH_B, SH_A};
      end
      4'd9: begin
        p.cnt = 3'd6; p.codes = {SH_A, SH_G, SH_F, SH_D, SH_C, SH_B, SH_A};
      end
      default: begin
        p.cnt = 3'd0;
      end
    endcase
    return p;
  endfunction

  // corner 0..3 of a non-slash shape: P0=(x0,y0) P1=(x1,y0) P2=(x1,y1) P3=(x0,y1)
  function automatic corner_t shape_corner(logic [3:0] code, logic [1:0] idx);
    corner_t    c;
    logic [2:0] x0, x1;
    logic [3:0] y0, y1;
    logic       slash;
    c     = '0;
    slash = 1'b0;
    x0 = 3'd0; x1 = 3'd0; y0 = 4'd0; y1 = 4'd0;
    c.known = 1'b1;
    unique case (code)
      SH_A:       begin x0 = 3'd1; x1 = 3'd5; y0 = 4'd0;  y1 = 4'd1;  end
      SH_B:       begin x0 = 3'd5; x1 = 3'd6; y0 = 4'd1;  y1 = 4'd5;  end
      SH_C:       begin x0 = 3'd5; x1 = 3'd6; y0 = 4'd6;  y1 = 4'd10; end
      SH_D:       begin x0 = 3'd1; x1 = 3'd5; y0 = 4'd10; y1 = 4'd11; end
      SH_E:       begin x0 = 3'd0; x1 = 3'd1; y0 = 4'd6;  y1 = 4'd10; end
      SH_F:       begin x0 = 3'd0; x1 = 3'd1; y0 = 4'd1;  y1 = 4'd5;  end
      SH_G:       begin x0 = 3'd1; x1 = 3'd5; y0 = 4'd5;  y1 = 4'd6;  end
      SH_DOT:     begin x0 = 3'd1; x1 = 3'd2; y0 = 4'd10; y1 = 4'd11; end
      SH_COL_TOP: begin x0 = 3'd1; x1 = 3'd2; y0 = 4'd3;  y1 = 4'd4;  end
      SH_COL_BOT: begin x0 = 3'd1; x1 = 3'd2; y0 = 4'd7;  y1 = 4'd8;  end
      SH_SLASH:   begin slash = 1'b1; end
      default:    begin c.known = 1'b0; end
    endcase
    if (slash) begin
      c.x = idx[1] ? 3'd1 : 3'd4;
      c.y = idx[1] ? 4'd11 : 4'd0;
    end else begin
      c.x = (idx == 2'd1 || idx == 2'd2) ? x1 : x0;
      c.y = idx[1] ? y1 : y0;
    end
    return c;
  endfunction

endpackage

// File: src/sstg_front.sv
// ----------------------------------------------------------------------------
// sstg_front
// Request intake: decodes each request into a shape plan and queues it.
// Digit requests above nine are taken and dropped.
// ----------------------------------------------------------------------------
module sstg_front #(
  parameter int COORD_BITS = 12,
  parameter int JOB_W      = 2 * COORD_BITS + 4 + $bits(sstg_pkg::plan_t)
) (
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_command,
  input  logic [COORD_BITS-1:0] in_origin_x,
  input  logic [COORD_BITS-1:0] in_origin_y,
  input  logic [3:0]            in_scale,
  input  logic [3:0]            in_symbol,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [JOB_W-1:0]      q_data
);

  sstg_pkg::plan_t plan;

  always_comb begin
    plan = sstg_pkg::digit_plan(in_symbol);
    if (in_command == sstg_pkg::CMD_SHAPE) begin
      plan.cnt      = 3'd1;
      plan.codes    = '0;
      plan.codes[0] = in_symbol;
    end
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full && (plan.cnt != 3'd0);
  assign q_data  = {in_origin_x, in_origin_y, in_scale, plan};

endmodule

// File: src/sstg_job_fifo.sv
// ----------------------------------------------------------------------------
// sstg_job_fifo
// Small register queue between request intake and triangle emission.
// ----------------------------------------------------------------------------
module sstg_job_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: src/sstg_back.sv
// ----------------------------------------------------------------------------
// sstg_back
// Triangle emitter: walks the shape plan of one queued request, two triangles
// per shape, one triangle per cycle into the output register while it is free or popped.
// ----------------------------------------------------------------------------
module sstg_back #(
  parameter int COORD_BITS = 12,
  parameter int JOB_W      = 2 * COORD_BITS + 4 + $bits(sstg_pkg::plan_t)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  logic [JOB_W-1:0]            q_data,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic signed [COORD_BITS:0]  out_vertex_a_x,
  output logic signed [COORD_BITS:0]  out_vertex_a_y,
  output logic signed [COORD_BITS:0]  out_vertex_b_x,
  output logic signed [COORD_BITS:0]  out_vertex_b_y,
  output logic signed [COORD_BITS:0]  out_vertex_c_x,
  output logic signed [COORD_BITS:0]  out_vertex_c_y,
  output logic                        out_last
);

  localparam int OUT_W  = COORD_BITS + 1;
  localparam int PLAN_W = $bits(sstg_pkg::plan_t);

  // current job
  logic                  job_vld_r, job_vld_nxt;
  sstg_pkg::plan_t       plan_r, plan_nxt;
  logic [COORD_BITS-1:0] ox_r, ox_nxt;
  logic [COORD_BITS-1:0] oy_r, oy_nxt;
  logic [3:0]            s_r, s_nxt;
  logic [2:0]            idx_r, idx_nxt;
  logic                  half_r, half_nxt;

  // output register
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0]      vx_r [3];
  logic [OUT_W-1:0]      vy_r [3];
  logic                  last_r;

  logic                  out_rdy, emit, last_tri;
  logic [3:0]            code;
  logic [1:0]            cidx [3];
  logic [OUT_W-1:0]      vx [3];
  logic [OUT_W-1:0]      vy [3];

  assign out_rdy  = !out_vld_r || out_pop;
  assign emit     = job_vld_r && out_rdy;
  assign last_tri = half_r && (idx_r == plan_r.cnt - 3'd1);
  assign q_pop    = !q_empty && (!job_vld_r || (emit && last_tri));
  assign code     = plan_r.codes[idx_r];

  // first triangle P0 P1 P2, second P2 P3 P0
  assign cidx[0] = half_r ? 2'd2 : 2'd0;
  assign cidx[1] = half_r ? 2'd3 : 2'd1;
  assign cidx[2] = half_r ? 2'd0 : 2'd2;

  for (genvar i = 0; i < 3; i++) begin : g_corner
    sstg_pkg::corner_t c;
    logic [7:0]        px, py;
    assign c  = sstg_pkg::shape_corner(code, cidx[i]);
    assign px = 8'(s_r) * 8'(c.x);
    assign py = 8'(s_r) * 8'(c.y);
    // unknown shapes land on (0,0), not offset by the origin
    assign vx[i] = c.known ? (OUT_W'(signed'(ox_r)) + OUT_W'(px)) : '0;
    assign vy[i] = c.known ? (OUT_W'(signed'(oy_r)) + OUT_W'(py)) : '0;
  end

  always_comb begin
    job_vld_nxt = job_vld_r;
    plan_nxt    = plan_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    s_nxt       = s_r;
    idx_nxt     = idx_r;
    half_nxt    = half_r;
    if (q_pop) begin
      job_vld_nxt = 1'b1;
      plan_nxt    = q_data[PLAN_W-1:0];
      s_nxt       = q_data[PLAN_W+3:PLAN_W];
      oy_nxt      = q_data[PLAN_W+4+COORD_BITS-1:PLAN_W+4];
      ox_nxt      = q_data[JOB_W-1:PLAN_W+4+COORD_BITS];
      idx_nxt     = '0;
      half_nxt    = 1'b0;
    end else if (emit) begin
      if (last_tri) begin
        job_vld_nxt = 1'b0;
      end else if (half_r) begin
        idx_nxt  = idx_r + 3'd1;
        half_nxt = 1'b0;
      end else begin
        half_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      idx_r     <= '0;
      half_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      job_vld_r <= job_vld_nxt;
      idx_r     <= idx_nxt;
      half_r    <= half_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plan_r <= plan_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    s_r    <= s_nxt;
    if (emit) begin
      vx_r   <= vx;
      vy_r   <= vy;
      last_r <= last_tri;
    end
  end

  assign out_empty      = !out_vld_r;
  assign out_vertex_a_x = vx_r[0];
  assign out_vertex_a_y = vy_r[0];
  assign out_vertex_b_x = vx_r[1];
  assign out_vertex_b_y = vy_r[1];
  assign out_vertex_c_x = vx_r[2];
  assign out_vertex_c_y = vy_r[2];
  assign out_last       = last_r;

endmodule

// File: src/seven_segment_triangle_generator_core.sv
// ----------------------------------------------------------------------------
// seven_segment_triangle_generator_core
// Turns digit and shape requests into filled triangles for a rasterizer.
// ----------------------------------------------------------------------------
// Each request yields two triangles per shape it draws: two for a single
// shape, 4 to 14 for a digit (14 for an eight), and none for a digit
// above nine. The emitter produces one triangle per cycle while its
// output register is free or popped, via three corner lookups; that loop
// sets the sustained rate. Requests are taken one per cycle while the
// job queue (QUEUE_DEPTH entries) has room, so the next request is decoded
// while the current one still emits; out_last marks each request's last triangle.
module seven_segment_triangle_generator_core #(
  parameter int COORD_BITS  = 12,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_command,
  input  logic signed [COORD_BITS-1:0] in_origin_x,
  input  logic signed [COORD_BITS-1:0] in_origin_y,
  input  logic [3:0]                  in_scale,
  input  logic [3:0]                  in_symbol,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic signed [COORD_BITS:0]  out_vertex_a_x,
  output logic signed [COORD_BITS:0]  out_vertex_a_y,
  output logic signed [COORD_BITS:0]  out_vertex_b_x,
  output logic signed [COORD_BITS:0]  out_vertex_b_y,
  output logic signed [COORD_BITS:0]  out_vertex_c_x,
  output logic signed [COORD_BITS:0]  out_vertex_c_y,
  output logic                        out_last
);

  localparam int JOB_W = 2 * COORD_BITS + 4 + $bits(sstg_pkg::plan_t);

  logic             q_push, q_full, q_pop, q_empty;
  logic [JOB_W-1:0] q_wdata, q_rdata;

  sstg_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_front (
    .in_push     (in_push),
    .in_full     (in_full),
    .in_command  (in_command),
    .in_origin_x (in_origin_x),
    .in_origin_y (in_origin_y),
    .in_scale    (in_scale),
    .in_symbol   (in_symbol),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  sstg_job_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sstg_back #(
    .COORD_BITS (COORD_BITS),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_vertex_a_x (out_vertex_a_x),
    .out_vertex_a_y (out_vertex_a_y),
    .out_vertex_b_x (out_vertex_b_x),
    .out_vertex_b_y (out_vertex_b_y),
    .out_vertex_c_x (out_vertex_c_x),
    .out_vertex_c_y (out_vertex_c_y),
    .out_last       (out_last)
  );

  // no triangle survives reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result pending right after reset");

  // emitter never dequeues from an empty job queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job queue popped while empty");

  // a shape request always lands in the job queue
  a_shape_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_command == sstg_pkg::CMD_SHAPE) |=> !q_empty)
    else $error("accepted shape request not queued");

endmodule

// File: tb/tb_seven_segment_triangle_generator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seven_segment_triangle_generator_core
// Drives digit and shape requests into the triangle generator and checks
// every triangle that comes out against a local model of the glyph
// geometry. Both queue sides idle at random, and one long receiver hold-off
// backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_seven_segment_triangle_generator_core;

  localparam int CB           = 12;
  localparam int DIRECTED_END = 25;
  localparam int RANDOM_ITEMS = 250;
  localparam int HOLD_AT      = 70;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [CB:0] ax, ay, bx, by, cx, cy;
    logic        last;
  } triangle_t;

  typedef logic [3:0] code_q_t[$];

  // --------------------------------------------------------------------------
  // glyph geometry model and store of expected triangles
  // --------------------------------------------------------------------------
  class triangle_scoreboard;
    triangle_t expected_tris[$];
    int        errors;
    int        checked;

    function code_q_t digit_segments(logic [3:0] digit);
      code_q_t segs;
      case (digit)
        4'd0: segs = '{sstg_pkg::SH_A, sstg_pkg::SH_B, sstg_pkg::SH_C,
                       sstg_pkg::SH_D, sstg_pkg::SH_E, sstg_pkg::SH_F};
        4'd1: segs = '{sstg_pkg::SH_B, sstg_pkg::SH_C};
        4'd2: segs = '{sstg_pkg::SH_A, sstg_pkg::SH_B, sstg_pkg::SH_G,
                       sstg_pkg::SH_E, sstg_pkg::SH_D};
        4'd3: segs = '{sstg_pkg::SH_A, sstg_pkg::SH_B, sstg_pkg::SH_G,
                       sstg_pkg::SH_C, sstg_pkg::SH_D};
        4'd4: segs = '{sstg_pkg::SH_B, sstg_pkg::SH_C, sstg_pkg::SH_G,
                       sstg_pkg::SH_F};
        4'd5: segs = '{sstg_pkg::SH_A, sstg_pkg::SH_F, sstg_pkg::SH_G,
                       sstg_pkg::SH_C, sstg_pkg::SH_D};
        4'd6: segs = '{sstg_pkg::SH_A, sstg_pkg::SH_F, sstg_pkg::SH_G,
                       sstg_pkg::SH_C, sstg_pkg::SH_D, sstg_pkg::SH_E};
        4'd7: segs = '{sstg_pkg::SH_A, sstg_pkg::SH_B, sstg_pkg::SH_C};
        4'd8: segs = '{sstg_pkg::SH_A, sstg_pkg::SH_B, sstg_pkg::SH_C,
                       sstg_pkg::SH_D, sstg_pkg::SH_E, sstg_pkg::SH_F,
                       sstg_pkg::SH_G};
        4'd9: segs = '{sstg_pkg::SH_A, sstg_pkg::SH_B, sstg_pkg::SH_C,
                       sstg_pkg::SH_D, sstg_pkg::SH_F, sstg_pkg::SH_G};
        default: segs = {};
      endcase
      return segs;
    endfunction

    function void add_shape(int ox, int oy, int sc, logic [3:0] code, bit fin);
      int        px[4];
      int        py[4];
      int        x0, x1, y0, y1;
      bit        known;
      triangle_t t;
      known = 1'b1;
      x0 = 0; x1 = 0; y0 = 0; y1 = 0;
      case (code)
        sstg_pkg::SH_A:       begin x0 = 1; x1 = 5; y0 = 0;  y1 = 1;  end
        sstg_pkg::SH_B:       begin x0 = 5; x1 = 6; y0 = 1;  y1 = 5;  end
        sstg_pkg::SH_C:       begin x0 = 5; x1 = 6; y0 = 6;  y1 = 10; end
        sstg_pkg::SH_D:       begin x0 = 1; x1 = 5; y0 = 10; y1 = 11; end
        sstg_pkg::SH_E:       begin x0 = 0; x1 = 1; y0 = 6;  y1 = 10; end
        sstg_pkg::SH_F:       begin x0 = 0; x1 = 1; y0 = 1;  y1 = 5;  end
        sstg_pkg::SH_G:       begin x0 = 1; x1 = 5; y0 = 5;  y1 = 6;  end
        sstg_pkg::SH_DOT:     begin x0 = 1; x1 = 2; y0 = 10; y1 = 11; end
        sstg_pkg::SH_COL_TOP: begin x0 = 1; x1 = 2; y0 = 3;  y1 = 4;  end
        sstg_pkg::SH_COL_BOT: begin x0 = 1; x1 = 2; y0 = 7;  y1 = 8;  end
        sstg_pkg::SH_SLASH:   begin x0 = 4; x1 = 1; y0 = 0;  y1 = 11; end
        default:              known = 1'b0;
      endcase
      for (int i = 0; i < 4; i++) begin
        if (!known) begin
          // unknown codes land on the display origin, not the cell origin
          px[i] = 0;
          py[i] = 0;
        end else if (code == sstg_pkg::SH_SLASH) begin
          px[i] = ox + sc * ((i < 2) ? x0 : x1);
          py[i] = oy + sc * ((i < 2) ? y0 : y1);
        end else begin
          px[i] = ox + sc * ((i == 1 || i == 2) ? x1 : x0);
          py[i] = oy + sc * ((i >= 2) ? y1 : y0);
        end
      end
      t.ax = px[0][CB:0]; t.ay = py[0][CB:0];
      t.bx = px[1][CB:0]; t.by = py[1][CB:0];
      t.cx = px[2][CB:0]; t.cy = py[2][CB:0];
      t.last = 1'b0;
      expected_tris.push_back(t);
      t.ax = px[2][CB:0]; t.ay = py[2][CB:0];
      t.bx = px[3][CB:0]; t.by = py[3][CB:0];
      t.cx = px[0][CB:0]; t.cy = py[0][CB:0];
      t.last = fin;
      expected_tris.push_back(t);
    endfunction

    function void note_request(logic cmd, logic [CB-1:0] ox, logic [CB-1:0] oy,
                               logic [3:0] sc, logic [3:0] sym);
      code_q_t segs;
      int      sx, sy;
      sx = $signed(ox);
      sy = $signed(oy);
      if (cmd == sstg_pkg::CMD_SHAPE) begin
        add_shape(sx, sy, sc, sym, 1'b1);
      end else begin
        segs = digit_segments(sym);
        foreach (segs[k]) add_shape(sx, sy, sc, segs[k], k == segs.size() - 1);
      end
    endfunction

    function void compare_field(string what, logic [CB:0] want, logic [CB:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what,
                 $signed(want), $signed(got));
      end
    endfunction

    function void check_triangle(triangle_t got);
      triangle_t want;
      checked++;
      if (expected_tris.size() == 0) begin
        errors++;
        $display("%0t: unexpected triangle (%0d,%0d) (%0d,%0d) (%0d,%0d) last=%0b",
                 $time, $signed(got.ax), $signed(got.ay), $signed(got.bx),
                 $signed(got.by), $signed(got.cx), $signed(got.cy), got.last);
        return;
      end
      want = expected_tris.pop_front();
      compare_field("vertex_a_x", want.ax, got.ax);
      compare_field("vertex_a_y", want.ay, got.ay);
      compare_field("vertex_b_x", want.bx, got.bx);
      compare_field("vertex_b_y", want.by, got.by);
      compare_field("vertex_c_x", want.cx, got.cx);
      compare_field("vertex_c_y", want.cy, got.cy);
      compare_field("last", {{CB{1'b0}}, want.last}, {{CB{1'b0}}, got.last});
    endfunction

    function int pending();
      return expected_tris.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_push = 1'b0;
  logic          in_full;
  logic          in_command = 1'b0;
  logic [CB-1:0] in_origin_x = '0;
  logic [CB-1:0] in_origin_y = '0;
  logic [3:0]    in_scale = '0;
  logic [3:0]    in_symbol = '0;
  logic          out_empty;
  logic          out_pop = 1'b0;
  logic [CB:0]   out_vertex_a_x, out_vertex_a_y;
  logic [CB:0]   out_vertex_b_x, out_vertex_b_y;
  logic [CB:0]   out_vertex_c_x, out_vertex_c_y;
  logic          out_last;

  triangle_scoreboard tri_book = new();

  bit quiet = 1'b0;
  bit hold_done = 1'b0;
  int req_count = 0;
  int digit_count = 0;
  int shape_count = 0;
  int full_stalls = 0;
  int idle_cycles = 0;

  seven_segment_triangle_generator_core #(.COORD_BITS(CB)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_scale       (in_scale),
    .in_symbol      (in_symbol),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_vertex_a_x (out_vertex_a_x),
    .out_vertex_a_y (out_vertex_a_y),
    .out_vertex_b_x (out_vertex_b_x),
    .out_vertex_b_y (out_vertex_b_y),
    .out_vertex_c_x (out_vertex_c_x),
    .out_vertex_c_y (out_vertex_c_y),
    .out_last       (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_origin();
    case ($urandom_range(0, 9))
      0:       return -2048;
      1:       return 2047;
      default: return $urandom_range(0, 4095) - 2048;
    endcase
  endfunction

  // returns at the edge where the request is taken
  task automatic send_request(input logic cmd, input int ox, input int oy,
                              input int sc, input int sym);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push     <= 1'b1;
    in_command  <= cmd;
    in_origin_x <= ox[CB-1:0];
    in_origin_y <= oy[CB-1:0];
    in_scale    <= sc[3:0];
    in_symbol   <= sym[3:0];
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // handshake monitor, checker and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    triangle_t got;
    if (rst_n) begin
      if (in_push && !in_full) begin
        tri_book.note_request(in_command, in_origin_x, in_origin_y, in_scale,
                              in_symbol);
        req_count++;
        if (in_command == sstg_pkg::CMD_SHAPE) shape_count++;
        else digit_count++;
      end
      if (in_push && in_full) full_stalls++;
      if (out_pop && !out_empty) begin
        got.ax = out_vertex_a_x; got.ay = out_vertex_a_y;
        got.bx = out_vertex_b_x; got.by = out_vertex_b_y;
        got.cx = out_vertex_c_x; got.cy = out_vertex_c_y;
        got.last = out_last;
        tri_book.check_triangle(got);
      end
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d triangles outstanding",
                 $time, IDLE_LIMIT, tri_book.pending());
        $display("seven_segment_triangle_generator_core test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_pop <= 1'b1;
    forever begin
      @(posedge clk);
      if (!hold_done && req_count >= HOLD_AT) begin
        // long hold-off: the sender keeps pushing until the block backs up
        hold_done = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_pop <= 1'b1;
      end else if (out_pop && !out_empty) begin
        gap = pick_gap();
        if (gap > 0) begin
          out_pop <= 1'b0;
          repeat (gap) @(posedge clk);
          out_pop <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender and end of test
  // --------------------------------------------------------------------------
  initial begin
    int       productive;
    logic     cmd;
    int       sym;
    int       ox;
    int       oy;
    int       sc;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // every digit, the first four at the coordinate extremes, scale zero on the eight
    send_request(sstg_pkg::CMD_DIGIT, -2048, -2048, 15, 0);
    send_request(sstg_pkg::CMD_DIGIT, 2047, 2047, 15, 1);
    send_request(sstg_pkg::CMD_DIGIT, -2048, 2047, 15, 2);
    send_request(sstg_pkg::CMD_DIGIT, 2047, -2048, 15, 3);
    send_request(sstg_pkg::CMD_DIGIT, 0, 0, 1, 4);
    send_request(sstg_pkg::CMD_DIGIT, 100, -100, 3, 5);
    send_request(sstg_pkg::CMD_DIGIT, -1, -1, 7, 6);
    send_request(sstg_pkg::CMD_DIGIT, 1234, -777, 2, 7);
    send_request(sstg_pkg::CMD_DIGIT, 5, 5, 0, 8);
    send_request(sstg_pkg::CMD_DIGIT, -500, 300, 15, 9);
    // digits above nine draw nothing
    send_request(sstg_pkg::CMD_DIGIT, 17, 33, 4, 10);
    send_request(sstg_pkg::CMD_DIGIT, -9, 2, 9, 15);
    // every shape, dot at scale zero
    for (int code = sstg_pkg::SH_A; code <= sstg_pkg::SH_SLASH; code++) begin
      send_request(sstg_pkg::CMD_SHAPE, code[0] ? 2047 : -2048,
                   code[0] ? -2048 : 2047,
                   (code == sstg_pkg::SH_DOT) ? 0 : 15 - code, code);
    end
    // unknown shape codes sit at (0,0) whatever the origin
    send_request(sstg_pkg::CMD_SHAPE, 321, -654, 5, sstg_pkg::SH_SLASH + 1);
    send_request(sstg_pkg::CMD_SHAPE, -2048, 2047, 15, 15);

    productive = 0;
    while (productive < RANDOM_ITEMS - DIRECTED_END) begin
      quiet = (productive >= 130 && productive < 180);
      cmd = ($urandom_range(0, 1) == 0) ? sstg_pkg::CMD_DIGIT : sstg_pkg::CMD_SHAPE;
      if (cmd == sstg_pkg::CMD_DIGIT)
        sym = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
      else
        sym = $urandom_range(0, 15);
      sc = $urandom_range(0, 15);
      ox = pick_origin();
      oy = pick_origin();
      send_request(cmd, ox, oy, sc, sym);
      if (cmd == sstg_pkg::CMD_SHAPE || sym <= 9) productive++;
    end
    in_push <= 1'b0;

    while (tri_book.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d digit, %0d shape), %0d triangles checked,",
             req_count, digit_count, shape_count, tri_book.checked);
    $display("%0d request cycles held off by full, %0d mismatches.",
             full_stalls, tri_book.errors);
    if (tri_book.errors == 0) begin
      $display("seven_segment_triangle_generator_core test passed");
    end else begin
      $display("seven_segment_triangle_generator_core test failed");
    end
    $finish;
  end

endmodule
